/* rtl/sfl_pkg.sv */
// Shared types and constants for the sorted table floor lookup block.
// No dependencies; the other files that use this package refer to it by scoped names.
package sfl_pkg;

	localparam int LEN_W = 11;
	localparam int IDX_IN_W = 10;
	localparam int KEY_W = 64;
	localparam int VAL_W = 31;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic wr;        // store the accepted entry
		logic load;      // start a lookup: capture address, set bounds
		logic rd_en;     // read the slot at the current midpoint
		logic step;      // compare the read key and narrow the bounds
		logic out_load;  // move the lookup answer to the output register
	} sfl_cmd_t;

	typedef struct packed {
		logic search_done;  // lower bound has met the upper bound
	} sfl_status_t;

endpackage

/* rtl/sfl_if.sv */
// Valid/ready channel interfaces for request and response words.
// Depends on sfl_pkg for field widths.
interface sfl_req_if;
	logic                         valid;
	logic                         ready;
	logic                         op;
	logic [sfl_pkg::IDX_IN_W-1:0] entry_index;
	logic [sfl_pkg::KEY_W-1:0]    entry_key;
	logic [sfl_pkg::VAL_W-1:0]    entry_value;
	logic [sfl_pkg::KEY_W-1:0]    search_address;

	modport source (
		output valid, op, entry_index, entry_key, entry_value, search_address,
		input  ready
	);
	modport sink (
		input  valid, op, entry_index, entry_key, entry_value, search_address,
		output ready
	);
endinterface

interface sfl_rsp_if;
	logic                      valid;
	logic                      ready;
	logic                      found;
	logic [sfl_pkg::VAL_W-1:0] line_value;

	modport source (
		output valid, found, line_value,
		input  ready
	);
	modport sink (
		input  valid, found, line_value,
		output ready
	);
endinterface

/* rtl/sfl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sfl_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

/* rtl/sfl_ctrl.sv */
// Sequencer for the floor lookup: accepts words, runs the probe loop, hands off results.
// Depends on sfl_pkg for the command and status structs and op codes.
module sfl_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  logic                 req_op,
	output logic                 req_ready,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output sfl_pkg::sfl_cmd_t    cmd,
	input  sfl_pkg::sfl_status_t status
);
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_PROBE = 2'd1;
	localparam logic [1:0] ST_CMP   = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       rsp_valid_q;
	logic       req_fire;
	logic       rsp_free;

	assign req_ready = (state_q == ST_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	// output register can take a new word when empty or draining this cycle
	assign rsp_free  = !rsp_valid_q || rsp_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					if (req_op == sfl_pkg::OP_LOOKUP) begin
						cmd.load = 1'b1;
						state_d  = ST_PROBE;
					end else begin
						cmd.wr = 1'b1;
					end
				end
			end
			ST_PROBE: begin
				if (status.search_done) begin
					state_d = ST_DONE;
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = ST_CMP;
				end
			end
			ST_CMP: begin
				cmd.step = 1'b1;
				state_d  = ST_PROBE;
			end
			ST_DONE: begin
				if (rsp_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end
endmodule

/* rtl/sfl_dpath.sv */
// Datapath for the floor lookup: key/value memories, search bounds, output register.
// Depends on sfl_pkg and sfl_ram.
module sfl_dpath #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sfl_pkg::sfl_cmd_t              cmd,
	output sfl_pkg::sfl_status_t           status,
	input  logic                           cfg_we,
	input  logic [sfl_pkg::LEN_W-1:0]      cfg_wdata,
	input  logic [sfl_pkg::IDX_IN_W-1:0]   entry_index,
	input  logic [sfl_pkg::KEY_W-1:0]      entry_key,
	input  logic [sfl_pkg::VAL_W-1:0]      entry_value,
	input  logic [sfl_pkg::KEY_W-1:0]      search_address,
	output logic                           found,
	output logic [sfl_pkg::VAL_W-1:0]      line_value
);
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	logic [sfl_pkg::LEN_W-1:0] table_length_q;
	logic [CNT_W-1:0]          eff_len;
	logic [CNT_W-1:0]          lo_q;
	logic [CNT_W-1:0]          hi_q;
	logic [CNT_W-1:0]          mid;
	logic [sfl_pkg::KEY_W-1:0] addr_q;
	logic [sfl_pkg::VAL_W-1:0] best_q;
	logic [sfl_pkg::KEY_W-1:0] key_rd;
	logic [sfl_pkg::VAL_W-1:0] val_rd;
	logic                      wr_en;
	logic [IDX_W-1:0]          waddr;
	logic                      hit;

	// saturate the configured length at the table depth
	assign eff_len = (32'(table_length_q) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
	                                                     : CNT_W'(table_length_q);
	assign mid     = lo_q + ((hi_q - lo_q) >> 1);
	assign hit     = (key_rd <= addr_q);
	assign status.search_done = (lo_q >= hi_q);

	// drop writes to slots beyond the table
	assign wr_en = cmd.wr && (32'(entry_index) < TABLE_DEPTH);
	assign waddr = IDX_W'(entry_index);

	sfl_ram #(
		.WIDTH (sfl_pkg::KEY_W),
		.DEPTH (TABLE_DEPTH)
	) u_key_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (waddr),
		.wdata (entry_key),
		.re    (cmd.rd_en),
		.raddr (mid[IDX_W-1:0]),
		.rdata (key_rd)
	);

	sfl_ram #(
		.WIDTH (sfl_pkg::VAL_W),
		.DEPTH (TABLE_DEPTH)
	) u_value_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (waddr),
		.wdata (entry_value),
		.re    (cmd.rd_en),
		.raddr (mid[IDX_W-1:0]),
		.rdata (val_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_length_q <= '0;
			lo_q           <= '0;
			hi_q           <= '0;
		end else begin
			if (cfg_we) begin
				table_length_q <= cfg_wdata;
			end
			if (cmd.load) begin
				lo_q <= '0;
				hi_q <= eff_len;
			end else if (cmd.step) begin
				if (hit) begin
					lo_q <= mid + CNT_W'(1);
				end else begin
					hi_q <= mid;
				end
			end
		end
	end

	// the last probe that hits is always the floor slot, so keep its value
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q <= search_address;
			best_q <= '0;
		end else if (cmd.step && hit) begin
			best_q <= val_rd;
		end
		if (cmd.out_load) begin
			found      <= (lo_q != '0);
			line_value <= (lo_q != '0) ? best_q : '0;
		end
	end
endmodule

/* rtl/sorted_table_floor_lookup_top.sv */
// Floor lookup over a sorted key/value table by binary search.
// Write word: stored when taken, leaving the controller idle. Lookup word: runs p probes,
// p <= ceil(log2(n + 1)) for n searched entries; each probe is one memory read
// then one compare, and no new word is taken until the result is handed off.
// The result waits in the done state until the output register is free.
// arst_n clears the controller, table length and output valid; memories are not cleared.
module sorted_table_floor_lookup_top #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	sfl_req_if.sink                   req,
	sfl_rsp_if.source                 rsp,
	input  logic                      cfg_we,
	input  logic [sfl_pkg::LEN_W-1:0] cfg_wdata
);
	sfl_pkg::sfl_cmd_t    cmd;
	sfl_pkg::sfl_status_t status;
	logic                 req_ready;
	logic                 rsp_valid;
	logic                 rsp_found;
	logic [sfl_pkg::VAL_W-1:0] rsp_line_value;

	assign req.ready      = req_ready;
	assign rsp.valid      = rsp_valid;
	assign rsp.found      = rsp_found;
	assign rsp.line_value = rsp_line_value;

	sfl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_op    (req.op),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd),
		.status    (status)
	);

	sfl_dpath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.entry_index    (req.entry_index),
		.entry_key      (req.entry_key),
		.entry_value    (req.entry_value),
		.search_address (req.search_address),
		.found          (rsp_found),
		.line_value     (rsp_line_value)
	);
endmodule
